// ----- sv/disk_request_cscan_scheduler_macros.svh -----
// Assertion macros shared by the disk request C-SCAN scheduler RTL.
`ifndef DISK_REQUEST_CSCAN_SCHEDULER_MACROS_SVH
`define DISK_REQUEST_CSCAN_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define DRCS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("drcs assertion failed");

// Checks that a condition holds in the cycle after a trigger.
`define DRCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drcs assertion failed");

`else

`define DRCS_ASSERT_ALWAYS(label, clk, rst, expr)
`define DRCS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/drcs_pkg.sv -----
// Package with types and constants of the disk request C-SCAN scheduler.
package drcs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TRACK_BITS_DEFAULT  = 16;
   localparam int TAG_BITS            = 8;
   localparam int STATUS_BITS         = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cell_ctrl_type;

endpackage

// ----- sv/drcs_req_if.sv -----
// Request channel interface: command, request fields and head position.
interface drcs_req_if #(
   parameter int TRACK_BITS = drcs_pkg::TRACK_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [TRACK_BITS-1:0]         req_track;
   logic [drcs_pkg::TAG_BITS-1:0] req_tag;
   logic [TRACK_BITS-1:0]         head_track;

   modport source (output valid, output cmd, output req_track, output req_tag,
                   output head_track, input ready);
   modport sink   (input valid, input cmd, input req_track, input req_tag,
                   input head_track, output ready);
endinterface

// ----- sv/drcs_rsp_if.sv -----
// Response channel interface: status and granted request.
interface drcs_rsp_if #(
   parameter int TRACK_BITS = drcs_pkg::TRACK_BITS_DEFAULT
);
   logic                             valid;
   logic                             ready;
   logic [drcs_pkg::STATUS_BITS-1:0] status;
   logic                             granted;
   logic [TRACK_BITS-1:0]            grant_track;
   logic [drcs_pkg::TAG_BITS-1:0]    grant_tag;
   logic                             wrapped;

   modport source (output valid, output status, output granted, output grant_track,
                   output grant_tag, output wrapped, input ready);
   modport sink   (input valid, input status, input granted, input grant_track,
                   input grant_tag, input wrapped, output ready);
endinterface

// ----- sv/drcs_cell.sv -----
// One slot of the request table with its stage of the running minimum search.
module drcs_cell #(
   parameter int TRACK_BITS = drcs_pkg::TRACK_BITS_DEFAULT,
   parameter int IDX_BITS   = 4,
   parameter int INDEX      = 0
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  drcs_pkg::cell_ctrl_type                        ctrl,
   input  logic [TRACK_BITS-1:0]                          head,
   input  logic [TRACK_BITS-1:0]                          new_track,
   input  logic [drcs_pkg::TAG_BITS-1:0]                  new_tag,
   input  logic [IDX_BITS-1:0]                            pick_index,
   input  logic                                           prev_valid,
   input  logic                                           next_valid,
   input  logic [TRACK_BITS-1:0]                          next_track,
   input  logic [drcs_pkg::TAG_BITS-1:0]                  next_tag,
   input  logic [TRACK_BITS+drcs_pkg::TAG_BITS+IDX_BITS+1:0] best_in,
   output logic                                           valid_q,
   output logic [TRACK_BITS-1:0]                          track_q,
   output logic [drcs_pkg::TAG_BITS-1:0]                  tag_q,
   output logic [TRACK_BITS+drcs_pkg::TAG_BITS+IDX_BITS+1:0] best_q
);

   localparam int BEST_W = TRACK_BITS + drcs_pkg::TAG_BITS + IDX_BITS + 2;

   logic                          valid_ff, valid_in;
   logic [TRACK_BITS-1:0]         track_ff, track_in;
   logic [drcs_pkg::TAG_BITS-1:0] tag_ff, tag_in;
   logic [BEST_W-1:0]             best_ff, best_in_d;

   logic                  in_found;
   logic                  in_wrap;
   logic [TRACK_BITS-1:0] in_track;
   logic                  own_below;
   logic                  beats;

   // Table update: a removal at or below this slot pulls the upper neighbor down,
   // an insert lands in the first free slot.
   always_comb begin
      valid_in = valid_ff;
      track_in = track_ff;
      tag_in   = tag_ff;
      if (ctrl.remove_en && (IDX_BITS'(INDEX) >= pick_index)) begin
         valid_in = next_valid;
         track_in = next_track;
         tag_in   = next_tag;
      end else if (ctrl.insert_en && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         track_in = new_track;
         tag_in   = new_tag;
      end
   end

   // Search key is {below head, track}; a strict compare keeps the older entry on a tie.
   assign in_found  = best_in[BEST_W-1];
   assign in_wrap   = best_in[BEST_W-2];
   assign in_track  = best_in[IDX_BITS+drcs_pkg::TAG_BITS +: TRACK_BITS];
   assign own_below = (track_ff < head);
   assign beats     = valid_ff && (!in_found || ({own_below, track_ff} < {in_wrap, in_track}));

   always_comb begin
      if (beats) begin
         best_in_d = {1'b1, own_below, track_ff, tag_ff, IDX_BITS'(INDEX)};
      end else begin
         best_in_d = best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      track_ff <= track_in;
      tag_ff   <= tag_in;
      best_ff  <= best_in_d;
   end

   assign valid_q = valid_ff;
   assign track_q = track_ff;
   assign tag_q   = tag_ff;
   assign best_q  = best_ff;

endmodule

// ----- sv/disk_request_cscan_scheduler.sv -----
// Top level of the C-SCAN disk request scheduler: control, cell chain, response register.
//
//   Channel   Direction  Moves per transfer
//   req_bus   in         cmd, req_track, req_tag, head_track
//   rsp_bus   out        status, granted, grant_track, grant_tag, wrapped
//
// An insert passes from the idle state through the commit state back to idle.
// A select passes through the scan state first: the best-candidate word ripples through
// the chain of cells one slot per cycle, and the scan counts through every slot.
// Reset is synchronous and empties the table at once; no clearing pass is needed.
// A stalled response holds the finished item in its register; the next request is
// still taken and worked on, and waits in the commit state until the register frees.
`include "disk_request_cscan_scheduler_macros.svh"

module disk_request_cscan_scheduler #(
   parameter int QUEUE_DEPTH = drcs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TRACK_BITS  = drcs_pkg::TRACK_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   drcs_req_if.sink  req_bus,
   drcs_rsp_if.source rsp_bus
);

   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int TAG_BITS = drcs_pkg::TAG_BITS;
   localparam int BEST_W   = TRACK_BITS + TAG_BITS + IDX_BITS + 2;

   // Control state.
   drcs_pkg::state_type state_ff, state_in;
   logic [IDX_BITS-1:0] cnt_ff, cnt_in;

   // The request being worked on.
   logic                  cmd_ff;
   logic [TRACK_BITS-1:0] head_ff;
   logic [TRACK_BITS-1:0] trk_ff;
   logic [TAG_BITS-1:0]   tag_ff;

   // Response register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [drcs_pkg::STATUS_BITS-1:0]    status_ff, status_in;
   logic                                granted_ff, granted_in;
   logic [TRACK_BITS-1:0]               gtrack_ff, gtrack_in;
   logic [TAG_BITS-1:0]                 gtag_ff, gtag_in;
   logic                                wrapped_ff, wrapped_in;

   // Cell chain taps.
   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic [TRACK_BITS-1:0]  track_arr [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]    tag_arr   [QUEUE_DEPTH];
   logic [BEST_W-1:0]      best_arr  [QUEUE_DEPTH];

   drcs_pkg::cell_ctrl_type cell_ctrl;
   logic                    accept;
   logic                    out_free;
   logic                    commit;
   logic                    empty;
   logic                    full;
   logic [BEST_W-1:0]       best;
   logic [IDX_BITS-1:0]     pick_index;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign empty    = !valid_vec[0];
   assign full     = valid_vec[QUEUE_DEPTH-1];

   // The last cell holds the winner once the search has rippled through every slot.
   assign best       = best_arr[QUEUE_DEPTH-1];
   assign pick_index = best[IDX_BITS-1:0];

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         drcs_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (req_bus.cmd == drcs_pkg::CMD_SELECT) begin
                  state_in = drcs_pkg::ST_SCAN;
               end else begin
                  state_in = drcs_pkg::ST_COMMIT;
               end
            end
         end
         drcs_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_BITS'(QUEUE_DEPTH - 1)) begin
               state_in = drcs_pkg::ST_COMMIT;
            end
         end
         drcs_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = drcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Output and control logic.
   always_comb begin
      req_bus.ready       = 1'b0;
      commit              = 1'b0;
      cell_ctrl.insert_en = 1'b0;
      cell_ctrl.remove_en = 1'b0;
      case (state_ff)
         drcs_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         drcs_pkg::ST_SCAN: begin
            req_bus.ready = 1'b0;
         end
         drcs_pkg::ST_COMMIT: begin
            commit              = out_free;
            cell_ctrl.insert_en = out_free && (cmd_ff == drcs_pkg::CMD_INSERT);
            cell_ctrl.remove_en = out_free && (cmd_ff == drcs_pkg::CMD_SELECT) && !empty;
         end
         default: begin
            commit = 1'b0;
         end
      endcase
   end

   // Response contents, loaded at commit.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      granted_in   = granted_ff;
      gtrack_in    = gtrack_ff;
      gtag_in      = gtag_ff;
      wrapped_in   = wrapped_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         status_in    = drcs_pkg::STATUS_OK;
         granted_in   = 1'b0;
         gtrack_in    = '0;
         gtag_in      = '0;
         wrapped_in   = 1'b0;
         if (cmd_ff == drcs_pkg::CMD_INSERT) begin
            if (full) begin
               status_in = drcs_pkg::STATUS_FULL;
            end
         end else if (empty) begin
            status_in = drcs_pkg::STATUS_EMPTY;
         end else begin
            granted_in = 1'b1;
            gtrack_in  = best[IDX_BITS+TAG_BITS +: TRACK_BITS];
            gtag_in    = best[IDX_BITS +: TAG_BITS];
            wrapped_in = best[BEST_W-2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drcs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff  <= req_bus.cmd;
         head_ff <= req_bus.head_track;
         trk_ff  <= req_bus.req_track;
         tag_ff  <= req_bus.req_tag;
      end
      status_ff  <= status_in;
      granted_ff <= granted_in;
      gtrack_ff  <= gtrack_in;
      gtag_ff    <= gtag_in;
      wrapped_ff <= wrapped_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.granted     = granted_ff;
   assign rsp_bus.grant_track = gtrack_ff;
   assign rsp_bus.grant_tag   = gtag_ff;
   assign rsp_bus.wrapped     = wrapped_ff;

   // The chain: slot 0 is the oldest request, the search enters at slot 0 and
   // leaves at the last slot, and removals pull entries down one slot.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                  prev_v;
      logic [BEST_W-1:0]     b_in;
      logic                  nxt_v;
      logic [TRACK_BITS-1:0] nxt_track;
      logic [TAG_BITS-1:0]   nxt_tag;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
         assign b_in   = '0;
      end else begin : g_inner
         assign prev_v = valid_vec[i-1];
         assign b_in   = best_arr[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign nxt_v     = 1'b0;
         assign nxt_track = '0;
         assign nxt_tag   = '0;
      end else begin : g_body
         assign nxt_v     = valid_vec[i+1];
         assign nxt_track = track_arr[i+1];
         assign nxt_tag   = tag_arr[i+1];
      end

      drcs_cell #(
         .TRACK_BITS (TRACK_BITS),
         .IDX_BITS   (IDX_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .head       (head_ff),
         .new_track  (trk_ff),
         .new_tag    (tag_ff),
         .pick_index (pick_index),
         .prev_valid (prev_v),
         .next_valid (nxt_v),
         .next_track (nxt_track),
         .next_tag   (nxt_tag),
         .best_in    (b_in),
         .valid_q    (valid_vec[i]),
         .track_q    (track_arr[i]),
         .tag_q      (tag_arr[i]),
         .best_q     (best_arr[i])
      );
   end

   // Valid slots always form a prefix starting at slot 0.
   `DRCS_ASSERT_ALWAYS(a_valid_prefix, clock, reset,
      ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)

   // A grant is only ever reported with an ok status.
   `DRCS_ASSERT_ALWAYS(a_grant_ok, clock, reset,
      !(rsp_bus.valid && rsp_bus.granted) || (rsp_bus.status == drcs_pkg::STATUS_OK))

   // A granted select removes exactly one entry.
   `DRCS_ASSERT_NEXT(a_remove_one, clock, reset, cell_ctrl.remove_en,
      $countones(valid_vec) == $past($countones(valid_vec)) - 1)

   // An insert into a table with room adds exactly one entry.
   `DRCS_ASSERT_NEXT(a_insert_one, clock, reset, cell_ctrl.insert_en && !full,
      $countones(valid_vec) == $past($countones(valid_vec)) + 1)

endmodule

// ----- tb/sv/disk_request_cscan_scheduler_tb.sv -----
// Self-checking testbench for the C-SCAN disk request scheduler.
module disk_request_cscan_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import drcs_pkg::*;

   localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT;
   localparam int TRACK_BITS  = TRACK_BITS_DEFAULT;
   // Long enough for the slowest command, a select, to finish while in flight.
   localparam int SETTLE_CYCLES = 2 * (QUEUE_DEPTH + 2);
   localparam int RANDOM_PER_PHASE = 375;
   localparam int REPORT_LIMIT = 10;

   // One command as it travels on the request channel.
   typedef struct packed {
      logic                  cmd;
      logic [TRACK_BITS-1:0] req_track;
      logic [TAG_BITS-1:0]   req_tag;
      logic [TRACK_BITS-1:0] head_track;
   } disk_cmd_t;

   // One scheduler answer as it travels on the response channel.
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   granted;
      logic [TRACK_BITS-1:0]  grant_track;
      logic [TAG_BITS-1:0]    grant_tag;
      logic                   wrapped;
   } grant_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   drcs_req_if #(.TRACK_BITS(TRACK_BITS)) req_bus ();
   drcs_rsp_if #(.TRACK_BITS(TRACK_BITS)) rsp_bus ();

   disk_request_cscan_scheduler #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TRACK_BITS  (TRACK_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // Commands waiting to be driven, and the answers the scheduler still owes us.
   disk_cmd_t cmd_backlog[$];
   grant_t    awaited_grants[$];

   // Our own copy of the pending-request table, kept in arrival order.
   logic [TRACK_BITS-1:0] sched_track [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]   sched_tag   [QUEUE_DEPTH];
   int                    sched_count = 0;

   // Percent of cycles in which the sender holds back and the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;
   int fail_count = 0;

   // The clock starts low so that the first rising edge comes after every
   // process is already waiting on it, which keeps the reset length exact.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Applies one accepted command to the table copy and returns the answer the
   // scheduler must give. The outward pass looks at every entry, so a request
   // above the head is found even when the oldest one lies below it.
   function automatic grant_t apply_disk_command(disk_cmd_t dc);
      grant_t g;
      int     pick;
      bit     found;
      g = '0;
      pick = 0;
      found = 1'b0;
      if (dc.cmd == CMD_INSERT) begin
         if (sched_count >= QUEUE_DEPTH) begin
            g.status = STATUS_FULL;
         end else begin
            sched_track[sched_count] = dc.req_track;
            sched_tag[sched_count] = dc.req_tag;
            sched_count++;
            g.status = STATUS_OK;
         end
      end else if (sched_count == 0) begin
         g.status = STATUS_EMPTY;
      end else begin
         // Strict less-than on both passes keeps the oldest entry on a tie.
         for (int i = 0; i < sched_count; i++) begin
            if (sched_track[i] >= dc.head_track &&
                (!found || sched_track[i] < sched_track[pick])) begin
               pick = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            g.wrapped = 1'b1;
            for (int i = 1; i < sched_count; i++) begin
               if (sched_track[i] < sched_track[pick]) begin
                  pick = i;
               end
            end
         end
         g.status = STATUS_OK;
         g.granted = 1'b1;
         g.grant_track = sched_track[pick];
         g.grant_tag = sched_tag[pick];
         // Close the gap so that the table stays in arrival order.
         for (int i = pick; i < sched_count - 1; i++) begin
            sched_track[i] = sched_track[i + 1];
            sched_tag[i] = sched_tag[i + 1];
         end
         sched_count--;
      end
      return g;
   endfunction

   // Sender. A transfer at this edge is fed to the table copy, then the channel
   // is loaded with the next command unless the sender chooses to idle.
   always @(posedge clock) begin : sender
      disk_cmd_t next_cmd;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.cmd <= CMD_INSERT;
         req_bus.req_track <= '0;
         req_bus.req_tag <= '0;
         req_bus.head_track <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_grants.push_back(apply_disk_command(
               {req_bus.cmd, req_bus.req_track, req_bus.req_tag, req_bus.head_track}));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_cmd = cmd_backlog.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.cmd <= next_cmd.cmd;
               req_bus.req_track <= next_cmd.req_track;
               req_bus.req_tag <= next_cmd.req_tag;
               req_bus.head_track <= next_cmd.head_track;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic note_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t",
                     field, want, got, $realtime);
         end
      end
   endtask

   // Receiver. Each response transfer is checked against the oldest awaited answer;
   // ready is redrawn every cycle so stalls land on every phase of the work.
   always @(posedge clock) begin : receiver
      grant_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_grants.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("response with nothing awaited: status %0d track 0x%0h at %0t",
                           rsp_bus.status, rsp_bus.grant_track, $realtime);
               end
            end else begin
               want = awaited_grants.pop_front();
               note_field("status", want.status, rsp_bus.status);
               note_field("granted", want.granted, rsp_bus.granted);
               note_field("grant_track", want.grant_track, rsp_bus.grant_track);
               note_field("grant_tag", want.grant_tag, rsp_bus.grant_tag);
               note_field("wrapped", want.wrapped, rsp_bus.wrapped);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic disk_cmd_t disk_cmd(logic c, int trk, int tg, int hd);
      return {c, TRACK_BITS'(trk), TAG_BITS'(tg), TRACK_BITS'(hd)};
   endfunction

   // Tracks lean on the edges and on a few shared values, so that ties, exact
   // head hits and wraps come up often; the rest spread over the whole range.
   function automatic logic [TRACK_BITS-1:0] pick_track();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return TRACK_BITS'($urandom_range(0, 7) * (1 << (TRACK_BITS - 3)));
         default: return TRACK_BITS'($urandom);
      endcase
   endfunction

   // Queues a random stretch in bursts. Insert-heavy bursts fill the table up to
   // full, select-heavy ones drain it to empty, balanced ones churn in between.
   task automatic queue_random(int count);
      int left;
      int burst;
      int insert_pct;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(8, 40);
         if (burst > left) begin
            burst = left;
         end
         case ($urandom_range(0, 2))
            0: insert_pct = 90;
            1: insert_pct = 50;
            default: insert_pct = 10;
         endcase
         repeat (burst) begin
            cmd_backlog.push_back({($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_SELECT,
                                   pick_track(), TAG_BITS'($urandom), pick_track()});
         end
         left -= burst;
      end
   endtask

   // Waits until every queued command has been taken and answered.
   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_bus.valid || awaited_grants.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end

      // Directed opening: select on an empty table, then a table whose oldest
      // request lies below the head, equal tracks for the age tie-break, both
      // track extremes, a wrap to the inner edge and a final drain to empty.
      cmd_backlog.push_back(disk_cmd(CMD_SELECT, 0, 0, 'hFFFF));
      cmd_backlog.push_back(disk_cmd(CMD_INSERT, 20, 'hFF, 0));
      cmd_backlog.push_back(disk_cmd(CMD_INSERT, 500, 'h01, 'hFFFF));
      cmd_backlog.push_back(disk_cmd(CMD_INSERT, 'hFFFF, 'h00, 0));
      cmd_backlog.push_back(disk_cmd(CMD_INSERT, 500, 'h02, 0));
      cmd_backlog.push_back(disk_cmd(CMD_INSERT, 0, 'h80, 0));
      cmd_backlog.push_back(disk_cmd(CMD_SELECT, 'hFFFF, 0, 300));
      cmd_backlog.push_back(disk_cmd(CMD_SELECT, 0, 'hFF, 300));
      cmd_backlog.push_back(disk_cmd(CMD_SELECT, 0, 0, 'hFFFF));
      cmd_backlog.push_back(disk_cmd(CMD_SELECT, 0, 0, 'h0100));
      cmd_backlog.push_back(disk_cmd(CMD_SELECT, 0, 0, 0));
      cmd_backlog.push_back(disk_cmd(CMD_SELECT, 'hFFFF, 'hFF, 0));

      // Four idling phases. Each one drains completely before the next starts,
      // which also pauses the sender until every awaited answer has come back.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 80; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 80; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         queue_random(RANDOM_PER_PHASE);
         wait_drained();
      end

      // Let any late or stray response show up before judging the run.
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (awaited_grants.size() != 0) begin
         fail_count += awaited_grants.size();
         $display("%0d answers never arrived", awaited_grants.size());
      end
      if (fail_count == 0) begin
         $display("** disk_request_cscan_scheduler: PASSED **");
      end else begin
         $display("** disk_request_cscan_scheduler: FAILED **");
      end
      $finish;
   end

   // Watchdog: the slowest correct run stays far below this.
   initial begin
      #5_000_000;
      $display("** disk_request_cscan_scheduler: FAILED **");
      $finish;
   end

endmodule
